### hw/rtl/sav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sav_pkg
// shared widths, payload types and register indexes of the score averager
// ---------------------------------------------------------------------------
package sav_pkg;

   localparam int CLASS_W    = 6;
   localparam int SCORE_W    = 16;
   localparam int SUM_W      = 20;
   localparam int AVG_W      = 16;
   localparam int DIV_W      = 5;
   localparam int NCLS_W     = 7;
   localparam int TOP_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSIFIERS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSES     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_COUNT       = 2'd2;

   typedef struct packed {
      logic [CLASS_W-1:0] class_index;
      logic [SCORE_W-1:0] score;
      logic               last_score;
   } req_type;

   typedef struct packed {
      logic [CLASS_W-1:0] chosen_class;
      logic [AVG_W-1:0]   average_score;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   // sum store commands
   typedef struct packed {
      logic acc;
      logic sweep_rd;
      logic clr;
   } sum_ctl_type;

   // one entry of the average store
   typedef struct packed {
      logic             chosen;
      logic [AVG_W-1:0] average;
   } avg_entry_type;

endpackage
`default_nettype wire

### hw/rtl/sav_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sav_if
// valid/ready channel carrying one payload word
// ---------------------------------------------------------------------------
interface sav_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

### hw/rtl/score_average_top_k_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// score_average_top_k_select
// sums class scores of several classifiers and emits the k best averages
// ---------------------------------------------------------------------------
//
//  channel  | dir | payload                                  | moves
//  ---------+-----+------------------------------------------+-----------------
//  req_if   | in  | class_index, score, last_score           | one score request
//  rsp_if   | out | chosen_class, average_score, last_result | one ranked class
//  csr_if   | in  | index, data                              | one register write
//
//  accumulation takes one request a cycle: a read-modify-write pipeline on the
//  sum memory, with a bypass when the same class arrives back to back
//  after the last request, a sweep divides every sum (MAX_CLASSES entries, one
//  at a time through the bit-serial divider) and clears the sum store;
//  then each result takes one pass over the average memory
//  after reset the sum memory is cleared entry by entry, no request taken
//  a stalled result waits in the output register; new requests are taken once
//  the last result has been loaded there
//
// ---------------------------------------------------------------------------
module score_average_top_k_select #(
   parameter int MAX_CLASSES = 64,
   parameter int MAX_TOP     = 16
) (
   input  logic  clock,
   input  logic  reset,
   sav_if.sink   req_if,
   sav_if.source rsp_if,
   sav_if.sink   csr_if
);
   import sav_pkg::*;

   localparam int AW = $clog2(MAX_CLASSES);
   localparam int CW = $clog2(MAX_CLASSES + 1);
   localparam int KW = $clog2(MAX_TOP + 1);
   localparam int EW = (CW > NCLS_W) ? CW : NCLS_W;
   localparam int IW = (CW > CLASS_W) ? CW : CLASS_W;
   localparam int TW = (KW > TOP_W) ? KW : TOP_W;
   localparam int XW = (CW > TW) ? CW : TW;

   localparam logic [DIV_W-1:0]  NUM_CLASSIFIERS_RST = 5'd1;
   localparam logic [NCLS_W-1:0] NUM_CLASSES_RST     = 7'd64;
   localparam logic [TOP_W-1:0]  TOP_COUNT_RST       = 5'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_ACCUM,
      ST_DRAIN,
      ST_DIV_RD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SEL,
      ST_EMIT
   } state_type;

   // configuration registers
   logic [DIV_W-1:0]  num_classifiers_ff;
   logic [NCLS_W-1:0] num_classes_ff;
   logic [TOP_W-1:0]  top_count_ff;

   // effective settings
   logic [DIV_W-1:0]  divisor_eff;
   logic [EW-1:0]     ncls_w;
   logic [CW-1:0]     classes_eff;
   logic [XW-1:0]     top_w;
   logic [KW-1:0]     k_eff;

   // sequencer
   state_type         state_ff, state_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     best_ff, best_in;
   logic [AVG_W-1:0]  best_avg_ff, best_avg_in;
   logic [KW-1:0]     round_ff, round_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              is_last;

   // request decode
   logic              req_accept;
   logic [IW-1:0]     cls_wide;
   logic              in_range;

   // memory and divider hookup
   sum_ctl_type       sum_ctl;
   logic [AW-1:0]     sum_addr;
   logic [SUM_W-1:0]  sum_rdata;
   logic              div_start;
   logic [AVG_W-1:0]  div_quotient;
   logic              div_done;
   logic              avg_wr;
   logic [AW-1:0]     avg_waddr;
   avg_entry_type     avg_wdata;
   logic              avg_rd;
   avg_entry_type     avg_rdata;

   // ------------------------------------------------------------------
   // configuration port, always ready
   // ------------------------------------------------------------------
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classifiers_ff <= NUM_CLASSIFIERS_RST;
         num_classes_ff     <= NUM_CLASSES_RST;
         top_count_ff       <= TOP_COUNT_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.payload.index)
            CSR_NUM_CLASSIFIERS: begin
               num_classifiers_ff <= csr_if.payload.data[DIV_W-1:0];
            end
            CSR_NUM_CLASSES: begin
               num_classes_ff <= csr_if.payload.data[NCLS_W-1:0];
            end
            CSR_TOP_COUNT: begin
               top_count_ff <= csr_if.payload.data[TOP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // zero divisor acts as one, class and result counts clamped
   always_comb begin
      divisor_eff = (num_classifiers_ff == '0) ? DIV_W'(1) : num_classifiers_ff;
      ncls_w      = (num_classes_ff == '0) ? EW'(1) : EW'(num_classes_ff);
      classes_eff = (ncls_w > EW'(MAX_CLASSES)) ? CW'(MAX_CLASSES) : CW'(ncls_w);
      top_w       = (top_count_ff == '0) ? XW'(1) : XW'(top_count_ff);
      if (top_w > XW'(MAX_TOP)) begin
         top_w = XW'(MAX_TOP);
      end
      if (top_w > XW'(classes_eff)) begin
         top_w = XW'(classes_eff);
      end
      k_eff = KW'(top_w);
   end

   // ------------------------------------------------------------------
   // request decode
   // ------------------------------------------------------------------
   assign req_if.ready = (state_ff == ST_ACCUM);
   assign req_accept   = req_if.valid && req_if.ready;
   assign cls_wide     = IW'(req_if.payload.class_index);
   // scores of classes past the store are dropped
   assign in_range     = cls_wide < IW'(MAX_CLASSES);
   assign is_last      = (round_ff == k_eff - KW'(1));

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_avg_in  = best_avg_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      sum_ctl      = '0;
      sum_addr     = idx_ff;
      div_start    = 1'b0;
      avg_wr       = 1'b0;
      avg_waddr    = idx_ff;
      avg_wdata    = '{chosen: 1'b0, average: div_quotient};
      avg_rd       = 1'b0;

      // compare stage of the selection pass, ties go to the later class
      if (cmp_valid_ff && !avg_rdata.chosen &&
          (!found_ff || avg_rdata.average >= best_avg_ff)) begin
         best_in     = cmp_idx_ff;
         best_avg_in = avg_rdata.average;
         found_in    = 1'b1;
      end

      case (state_ff)
         ST_CLEAR: begin
            sum_ctl.clr = 1'b1;
            if (idx_ff == AW'(MAX_CLASSES - 1)) begin
               idx_in   = '0;
               state_in = ST_ACCUM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_ACCUM: begin
            sum_addr    = AW'(cls_wide);
            sum_ctl.acc = req_accept && in_range;
            if (req_accept && req_if.payload.last_score) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last accumulate write lands this cycle
            idx_in   = '0;
            state_in = ST_DIV_RD;
         end
         ST_DIV_RD: begin
            sum_ctl.sweep_rd = 1'b1;
            state_in         = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            // sum is latched by the divider, entry cleared for the next set
            div_start   = 1'b1;
            sum_ctl.clr = 1'b1;
            state_in    = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               avg_wr = 1'b1;
               if (idx_ff == AW'(MAX_CLASSES - 1)) begin
                  scan_in  = '0;
                  found_in = 1'b0;
                  round_in = '0;
                  state_in = ST_SEL;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_DIV_RD;
               end
            end
         end
         ST_SEL: begin
            if (scan_ff < classes_eff) begin
               avg_rd       = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[AW-1:0];
               scan_in      = scan_ff + 1'b1;
            end
            if (cmp_valid_ff && cmp_idx_ff == AW'(classes_eff - CW'(1))) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.chosen_class  = CLASS_W'(best_ff);
               rsp_in.average_score = best_avg_ff;
               rsp_in.last_result   = is_last;
               // mark the winner so later passes skip it
               avg_wr    = 1'b1;
               avg_waddr = best_ff;
               avg_wdata = '{chosen: 1'b1, average: best_avg_ff};
               if (is_last) begin
                  state_in = ST_ACCUM;
               end else begin
                  round_in = round_ff + 1'b1;
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SEL;
               end
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         scan_ff      <= scan_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff  <= cmp_idx_in;
      best_ff     <= best_in;
      best_avg_ff <= best_avg_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // ------------------------------------------------------------------
   // datapath parts
   // ------------------------------------------------------------------
   sav_sum_store #(
      .DEPTH (MAX_CLASSES)
   ) u_sum_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sum_ctl),
      .addr    (sum_addr),
      .score   (req_if.payload.score),
      .rd_data (sum_rdata)
   );

   sav_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_rdata),
      .divisor  (divisor_eff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   sav_avg_store #(
      .DEPTH (MAX_CLASSES)
   ) u_avg_store (
      .clock   (clock),
      .wr_en   (avg_wr),
      .wr_addr (avg_waddr),
      .wr_data (avg_wdata),
      .rd_en   (avg_rd),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (avg_rdata)
   );

`ifndef ASSERT_OFF
   a_div_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside the divide sweep");

   a_emit_has_winner : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> found_ff)
      else $error("result emitted without a selected class");

   a_emit_in_range : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> CW'(best_ff) < classes_eff)
      else $error("selected class outside the active class range");
`endif

endmodule
`default_nettype wire

### hw/rtl/sav_sum_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sav_sum_store
// per-class sum memory with a read-modify-write accumulate pipeline
// ---------------------------------------------------------------------------
module sav_sum_store #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sav_pkg::sum_ctl_type         ctl,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   input  logic [sav_pkg::SCORE_W-1:0]  score,
   output logic [sav_pkg::SUM_W-1:0]    rd_data
);
   import sav_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [SUM_W-1:0]   mem [DEPTH];
   logic [SUM_W-1:0]   rd_data_ff;
   logic               s1_valid_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic [SCORE_W-1:0] s1_score_ff;
   logic               fwd_ff;
   logic               fwd_in;
   logic [SUM_W-1:0]   fwd_data_ff;
   logic [SUM_W-1:0]   base;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;

   // saturating add, bypassing the write of the previous cycle
   always_comb begin
      base     = fwd_ff ? fwd_data_ff : rd_data_ff;
      sum_wide = {1'b0, base} + (SUM_W+1)'(s1_score_ff);
      sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      fwd_in   = ctl.acc && s1_valid_ff && (addr == s1_addr_ff);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem[s1_addr_ff] <= sum_sat;
      end else if (ctl.clr) begin
         mem[addr] <= '0;
      end
      if (ctl.acc || ctl.sweep_rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.acc;
         fwd_ff      <= fwd_in;
      end
      s1_addr_ff  <= addr;
      s1_score_ff <= score;
      fwd_data_ff <= sum_sat;
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/sav_avg_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sav_avg_store
// average memory with chosen marks, one write and one registered read port
// ---------------------------------------------------------------------------
module sav_avg_store #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  sav_pkg::avg_entry_type        wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output sav_pkg::avg_entry_type        rd_data
);
   import sav_pkg::*;

   avg_entry_type mem [DEPTH];
   avg_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/sav_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sav_divider
// restoring divider, one quotient bit a cycle, saturating at full scale
// ---------------------------------------------------------------------------
module sav_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sav_pkg::SUM_W-1:0]   dividend,
   input  logic [sav_pkg::DIV_W-1:0]   divisor,
   output logic [sav_pkg::AVG_W-1:0]   quotient,
   output logic                        done
);
   import sav_pkg::*;

   localparam int HI_W   = SUM_W - AVG_W;
   localparam int STEP_W = $clog2(AVG_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  rem_in;
   logic [DIV_W-1:0]  div_ff;
   logic [AVG_W-1:0]  work_ff;
   logic [DIV_W:0]    trial;
   logic              ge;
   logic              sat;

   always_comb begin
      trial  = {rem_ff, work_ff[AVG_W-1]};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? DIV_W'(trial - {1'b0, div_ff}) : DIV_W'(trial);
      // quotient at or above full scale when the high part reaches the divisor
      sat    = (DIV_W+1)'(dividend[SUM_W-1:AVG_W]) >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= !sat;
            done_ff <= sat;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(AVG_W-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff  <= DIV_W'(dividend[SUM_W-1:AVG_W]);
         div_ff  <= divisor;
         work_ff <= sat ? '1 : dividend[AVG_W-1:0];
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         work_ff <= {work_ff[AVG_W-2:0], ge};
      end
   end

   assign quotient = work_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire
